FILE: hdl/assert_macros.svh
// Assertion macros shared by the point-in-polygon RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define PIP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PIP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/pip_pkg.sv
// Types and constants shared by the point-in-polygon modules.
package pip_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int COORD_WIDTH      = 16;
   localparam int VIDX_WIDTH       = 6;
   localparam int COUNT_WIDTH      = 7;
   localparam int MIN_VERTICES     = 3;
   localparam int DIFF_WIDTH       = COORD_WIDTH + 1;
   localparam int PROD_WIDTH       = 2 * DIFF_WIDTH;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;

   typedef struct packed {
      logic                   op;
      logic [VIDX_WIDTH-1:0]  vertex_index;
      coord_type              coord_x;
      coord_type              coord_y;
   } req_type;

   typedef struct packed {
      logic inside_res;
      logic too_few_vertices;
   } rsp_type;

   typedef struct packed {
      logic wr_en;
      logic start;
      logic rd_en;
      logic edge_en;
      logic load;
      logic few;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

endpackage

FILE: hdl/pip_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/pip_ctrl.sv
// Controller: request handshake, vertex count register and edge scan sequencing.
`include "assert_macros.svh"

module pip_ctrl #(
   parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_op,
   output logic                               req_stall,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic                               csr_we,
   input  logic [pip_pkg::COUNT_WIDTH-1:0]    csr_wdata,
   input  logic                               busy,
   output pip_pkg::cmd_type                   cmd,
   output logic [$clog2(MAX_VERTICES)-1:0]    rd_addr
);
   import pip_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int NW = $clog2(MAX_VERTICES + 1);

   state_type              state_ff, state_in;
   logic [NW-1:0]          cnt_ff, cnt_in;
   logic [NW-1:0]          n_ff, n_in;
   logic                   few_ff, few_in;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0]          n_clamp;
   logic                   n_few;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         n_ff         <= '0;
         few_ff       <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         n_ff         <= n_in;
         few_ff       <= few_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
      end
   end

   // Clamp the programmed count to the table depth.
   assign n_clamp = (32'(count_ff) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(count_ff);
   assign n_few   = n_clamp < NW'(MIN_VERTICES);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      few_in       = few_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      req_stall    = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_op == OP_WRITE) begin
                  cmd.wr_en = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  n_in      = n_clamp;
                  few_in    = n_few;
                  cnt_in    = '0;
                  state_in  = n_few ? ST_FINISH : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // First read primes the last vertex, then one edge per read.
            cmd.rd_en   = 1'b1;
            cmd.edge_en = (cnt_ff != '0);
            cnt_in      = cnt_ff + NW'(1);
            if (cnt_ff == n_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load     = 1'b1;
               cmd.few      = few_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_addr   = (cnt_ff == '0) ? AW'(n_ff - NW'(1)) : AW'(cnt_ff - NW'(1));
   assign rsp_valid = rsp_valid_ff;

   `PIP_ASSERT(a_finish_after_drain, (state_ff == ST_FINISH) |-> !busy,
      "result loaded while edge pipeline still busy")
   `PIP_ASSERT(a_scan_bound, (state_ff == ST_SCAN) |-> (cnt_ff <= n_ff),
      "edge scan ran past vertex count")
   `PIP_ASSERT(a_rsp_from_finish, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH),
      "response raised outside finish state")

endmodule

FILE: hdl/pip_datapath.sv
// Datapath: vertex memory, edge straddle test, cross products and parity.
`include "assert_macros.svh"

module pip_datapath #(
   parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pip_pkg::cmd_type                cmd,
   input  logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
   input  pip_pkg::req_type                req_data,
   output logic                            busy,
   output pip_pkg::rsp_type                rsp_data
);
   import pip_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);

   logic                     slot_ok;
   logic [2*COORD_WIDTH-1:0] ram_rd_data;
   coord_type                xi, yi;
   coord_type                px_ff, py_ff;
   coord_type                prev_x_ff, prev_y_ff;
   logic                     rd_v_ff, edge_d1_ff;
   logic                     straddle;
   logic                     a_v_ff, a_edge_ff, a_dypos_ff;
   diff_type                 a_dx_ff, a_dy_ff, a_ax_ff, a_ay_ff;
   logic                     b_v_ff, b_edge_ff, b_dypos_ff;
   prod_type                 b_p1_ff, b_p2_ff;
   logic                     left;
   logic                     parity_ff;
   logic                     rsp_inside_ff, rsp_few_ff;

   assign slot_ok = 32'(req_data.vertex_index) < MAX_VERTICES;

   pip_ram #(
      .WIDTH(2 * COORD_WIDTH),
      .DEPTH(MAX_VERTICES)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en && slot_ok),
      .wr_addr (AW'(req_data.vertex_index)),
      .wr_data ({req_data.coord_x, req_data.coord_y}),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   assign xi = ram_rd_data[2*COORD_WIDTH-1:COORD_WIDTH];
   assign yi = ram_rd_data[COORD_WIDTH-1:0];

   // Edge counts when exactly one end lies strictly above the query y.
   assign straddle = (yi > py_ff) != (prev_y_ff > py_ff);

   assign left = b_dypos_ff ? (b_p1_ff < b_p2_ff) : (b_p2_ff < b_p1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff    <= 1'b0;
         edge_d1_ff <= 1'b0;
         a_v_ff     <= 1'b0;
         a_edge_ff  <= 1'b0;
         b_v_ff     <= 1'b0;
         b_edge_ff  <= 1'b0;
         parity_ff  <= 1'b0;
      end else begin
         rd_v_ff    <= cmd.rd_en;
         edge_d1_ff <= cmd.edge_en;
         a_v_ff     <= rd_v_ff;
         a_edge_ff  <= edge_d1_ff && straddle;
         b_v_ff     <= a_v_ff;
         b_edge_ff  <= a_edge_ff;
         if (cmd.start) begin
            parity_ff <= 1'b0;
         end else if (b_edge_ff && left) begin
            parity_ff <= !parity_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         px_ff <= req_data.coord_x;
         py_ff <= req_data.coord_y;
      end
      if (rd_v_ff) begin
         prev_x_ff <= xi;
         prev_y_ff <= yi;
      end
      a_dx_ff    <= diff_type'(prev_x_ff) - diff_type'(xi);
      a_dy_ff    <= diff_type'(prev_y_ff) - diff_type'(yi);
      a_ax_ff    <= diff_type'(px_ff) - diff_type'(xi);
      a_ay_ff    <= diff_type'(py_ff) - diff_type'(yi);
      a_dypos_ff <= prev_y_ff > yi;
      b_p1_ff    <= prod_type'(a_ax_ff) * prod_type'(a_dy_ff);
      b_p2_ff    <= prod_type'(a_dx_ff) * prod_type'(a_ay_ff);
      b_dypos_ff <= a_dypos_ff;
      if (cmd.load) begin
         rsp_inside_ff <= cmd.few ? 1'b0 : parity_ff;
         rsp_few_ff    <= cmd.few;
      end
   end

   assign busy                      = rd_v_ff || a_v_ff || b_v_ff;
   assign rsp_data.inside_res       = rsp_inside_ff;
   assign rsp_data.too_few_vertices = rsp_few_ff;

   `PIP_ASSERT_ALWAYS(a_edge_in_flight, a_edge_ff |-> a_v_ff,
      "edge flagged without a memory read behind it")
   `PIP_ASSERT(a_stage_order, b_v_ff |-> $past(a_v_ff),
      "product stage valid without a preceding difference stage")

endmodule

FILE: hdl/point_in_polygon_crossing_core.sv
// Top level of the even-odd point-in-polygon block.
// Holds up to MAX_VERTICES polygon vertices in a single-port-read memory and
// answers point queries by even-odd ray casting with exact cross products.
// A vertex write request is accepted without a response; a query
// with n = min(vertex_count, MAX_VERTICES) of three or more is paced by one
// vertex-memory read per edge plus the difference/multiply/compare pipeline.
// A query with fewer than three vertices answers with too_few_vertices set.
// Requests are taken only while no query is in progress; a finished response
// waits in an output register and does not block the next request.
module point_in_polygon_crossing_core #(
   parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  pip_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output pip_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [pip_pkg::COUNT_WIDTH-1:0] csr_wdata
);
   import pip_pkg::*;

   cmd_type                         cmd;
   logic                            busy;
   logic [$clog2(MAX_VERTICES)-1:0] rd_addr;

   pip_ctrl #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .busy      (busy),
      .cmd       (cmd),
      .rd_addr   (rd_addr)
   );

   pip_datapath #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .rd_addr  (rd_addr),
      .req_data (req_data),
      .busy     (busy),
      .rsp_data (rsp_data)
   );

endmodule

FILE: dv/point_in_polygon_crossing_checker.sv
// Checker for the point-in-polygon block: predicts each query answer and compares responses.
module point_in_polygon_crossing_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  pip_pkg::req_type                req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  pip_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [pip_pkg::COUNT_WIDTH-1:0] csr_wdata,
   output int                              error_count,
   output int                              open_count
);
   import pip_pkg::*;

   coord_type              vert_x [MAX_VERTICES_DEF];
   coord_type              vert_y [MAX_VERTICES_DEF];
   logic [COUNT_WIDTH-1:0] poly_count;
   rsp_type                expected_verdicts [$];

   // Even-odd crossing count over the stored polygon, done with exact products.
   function automatic rsp_type crossing_verdict(coord_type px, coord_type py);
      rsp_type  verdict;
      int       n_used;
      int       j;
      diff_type dx;
      diff_type dy;
      diff_type ex;
      diff_type ey;
      logic     left;
      verdict = '0;
      n_used = (poly_count > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : int'(poly_count);
      if (n_used < MIN_VERTICES) begin
         verdict.too_few_vertices = 1'b1;
         return verdict;
      end
      j = n_used - 1;
      for (int i = 0; i < n_used; i++) begin
         if ((vert_y[i] > py) != (vert_y[j] > py)) begin
            dy = diff_type'(vert_y[j]) - diff_type'(vert_y[i]);
            dx = diff_type'(vert_x[j]) - diff_type'(vert_x[i]);
            ex = diff_type'(px) - diff_type'(vert_x[i]);
            ey = diff_type'(py) - diff_type'(vert_y[i]);
            // flip the comparison when the edge runs downward
            if (dy > 0)
               left = (prod_type'(ex) * prod_type'(dy)) < (prod_type'(dx) * prod_type'(ey));
            else
               left = (prod_type'(dx) * prod_type'(ey)) < (prod_type'(ex) * prod_type'(dy));
            if (left)
               verdict.inside_res = ~verdict.inside_res;
         end
         j = i;
      end
      return verdict;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_verdicts.delete();
         poly_count = '0;
         error_count = 0;
      end else begin
         // a response at this edge belongs to an earlier request
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch: response inside=%0b few=%0b with no query waiting",
                           rsp_data.inside_res, rsp_data.too_few_vertices);
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_data.inside_res !== want.inside_res ||
                   rsp_data.too_few_vertices !== want.too_few_vertices) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("mismatch: expected inside=%0b few=%0b, got inside=%0b few=%0b",
                              want.inside_res, want.too_few_vertices,
                              rsp_data.inside_res, rsp_data.too_few_vertices);
               end
            end
         end
         if (csr_we)
            poly_count = csr_wdata;
         if (req_valid && !req_stall) begin
            if (req_data.op == OP_WRITE) begin
               vert_x[req_data.vertex_index] = req_data.coord_x;
               vert_y[req_data.vertex_index] = req_data.coord_y;
            end else begin
               expected_verdicts.push_back(crossing_verdict(req_data.coord_x, req_data.coord_y));
            end
         end
      end
      open_count = expected_verdicts.size();
   end

endmodule

FILE: dv/point_in_polygon_crossing_core_tb.sv
// Testbench top for the point-in-polygon block: vertex writes, point queries and the verdict.
module point_in_polygon_crossing_core_tb;
   import pip_pkg::*;

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int REQUEST_TARGET = 1700;
   localparam int DRAIN_CYCLES   = 80;
   localparam int SETTLE_CYCLES  = 8;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we = 1'b0;
   logic [COUNT_WIDTH-1:0] csr_wdata = '0;
   int                     error_count;
   int                     open_count;
   int                     sent_count = 0;
   int                     cycle_count = 0;
   bit                     calm = 1'b0;
   int                     shadow_x [MAX_VERTICES_DEF];
   int                     shadow_y [MAX_VERTICES_DEF];

   always #2 clock = ~clock;

   point_in_polygon_crossing_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   point_in_polygon_crossing_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .open_count  (open_count)
   );

   always @(posedge clock) begin
      rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 29);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL point_in_polygon_crossing_core");
         $finish;
      end
   end

   function automatic int fit_coord(int v);
      if (v > 32767)
         return 32767;
      if (v < -32768)
         return -32768;
      return v;
   endfunction

   function automatic int spread(int center, int radius);
      return fit_coord(center + int'($urandom_range(2 * radius)) - radius);
   endfunction

   task automatic send_request(input logic op, input int slot, input int x, input int y);
      req_type r;
      r.op = op;
      r.vertex_index = slot[VIDX_WIDTH-1:0];
      r.coord_x = coord_type'(x);
      r.coord_y = coord_type'(y);
      while (!calm && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (op == OP_WRITE) begin
         shadow_x[r.vertex_index] = x;
         shadow_y[r.vertex_index] = y;
      end
      sent_count++;
      calm = (sent_count >= 700 && sent_count < 1000);
   endtask

   // Drain every open query, let the last write settle, then load the count.
   task automatic set_vertex_count(input logic [COUNT_WIDTH-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_count != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int count;
      int n_used;
      int n_queries;
      int cx;
      int cy;
      int radius;
      int pick;
      int slot;
      int v;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty polygon, then a square with points inside, outside and on its edges and corners
      send_request(OP_QUERY, 0, -32768, 32767);
      send_request(OP_WRITE, 63, 32767, -1);
      send_request(OP_WRITE, 0, 0, 0);
      send_request(OP_WRITE, 1, 10, 0);
      send_request(OP_WRITE, 2, 10, 10);
      send_request(OP_WRITE, 3, 0, 10);
      set_vertex_count(7'd4);
      send_request(OP_QUERY, 0, 5, 5);
      send_request(OP_QUERY, 1, 0, 5);
      send_request(OP_QUERY, 2, 10, 5);
      send_request(OP_QUERY, 3, 5, 0);
      send_request(OP_QUERY, 4, 5, 10);
      send_request(OP_QUERY, 5, 0, 0);
      send_request(OP_QUERY, 6, -1, 5);
      send_request(OP_QUERY, 7, 11, 5);
      set_vertex_count(7'd2);
      send_request(OP_QUERY, 0, 5, 5);
      // triangle spanning the whole coordinate range
      send_request(OP_WRITE, 0, -32768, -32768);
      send_request(OP_WRITE, 1, 32767, -32768);
      send_request(OP_WRITE, 2, 0, 32767);
      set_vertex_count(7'd3);
      send_request(OP_QUERY, 0, 0, 0);
      send_request(OP_QUERY, 0, -32768, -32768);
      send_request(OP_QUERY, 63, 32767, 32767);
      send_request(OP_QUERY, 0, 0, -32768);
      send_request(OP_QUERY, 0, -32768, 32767);
      send_request(OP_QUERY, 0, 16383, 0);

      // random polygons, each written in full before it is queried
      while (sent_count < REQUEST_TARGET) begin
         pick = $urandom_range(99);
         if (pick < 6)
            count = $urandom_range(2);
         else if (pick < 10)
            count = 64;
         else if (pick < 14)
            count = $urandom_range(1) ? 127 : $urandom_range(127, 65);
         else if (pick < 30)
            count = $urandom_range(24, 9);
         else
            count = $urandom_range(8, 3);
         n_used = (count > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : count;
         set_vertex_count(COUNT_WIDTH'(count));
         pick = $urandom_range(99);
         if (pick < 30)
            radius = $urandom_range(16, 1);
         else if (pick < 80)
            radius = $urandom_range(3000, 100);
         else
            radius = 32767;
         cx = int'($urandom_range(65535)) - 32768;
         cy = int'($urandom_range(65535)) - 32768;
         for (int k = 0; k < n_used; k++)
            send_request(OP_WRITE, k, spread(cx, radius), spread(cy, radius));
         n_queries = $urandom_range(24, 8);
         for (int k = 0; k < n_queries; k++) begin
            pick = $urandom_range(99);
            slot = $urandom_range(63);
            v = (n_used > 0) ? $urandom_range(n_used - 1) : 0;
            if (pick < 8)
               send_request(OP_WRITE, slot, spread(cx, radius), spread(cy, radius));
            else if (pick < 60 || n_used == 0)
               send_request(OP_QUERY, slot, spread(cx, radius + radius / 4 + 1),
                            spread(cy, radius + radius / 4 + 1));
            else if (pick < 80)
               // land on a vertex height to hit the straddle boundary
               send_request(OP_QUERY, slot, spread(cx, radius + 1), shadow_y[v]);
            else if (pick < 90)
               send_request(OP_QUERY, slot, shadow_x[v], shadow_y[v]);
            else
               send_request(OP_QUERY, slot, int'($urandom_range(65535)) - 32768,
                            int'($urandom_range(65535)) - 32768);
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (open_count != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && open_count == 0)
         $display("PASS point_in_polygon_crossing_core");
      else
         $display("FAIL point_in_polygon_crossing_core");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/pip_pkg.sv
hdl/pip_ram.sv
hdl/pip_ctrl.sv
hdl/pip_datapath.sv
hdl/point_in_polygon_crossing_core.sv
dv/point_in_polygon_crossing_checker.sv
dv/point_in_polygon_crossing_core_tb.sv
